// ===== rtl/csu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_pkg
// Shared types, widths and helpers for the cosine similarity unit.
// ----------------------------------------------------------------------------
package csu_pkg;

    localparam int MAX_LEN_DEF  = 128;
    localparam int ELEM_W       = 16;
    localparam int SIM_W        = 16;
    localparam int R_W          = 15;
    localparam int FRAC_SHIFT   = 28;
    localparam int CHUNK_W      = 16;
    localparam int CHUNK_IDX_W  = 2;
    localparam int BIT_IDX_W    = $clog2(R_W);

    localparam logic signed [SIM_W-1:0] SIM_ONE = 16'sd16384;

    // bits to hold MAX_LEN squared 16-bit magnitudes
    function automatic int norm_w(input int max_len);
        return 30 + $clog2(max_len + 1);
    endfunction

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL_P,
        ST_MUL_L,
        ST_SRCH_A,
        ST_SRCH_B,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                   take;
        logic                   mul_p;
        logic                   mul_l;
        logic                   first;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic                   srch_init;
        logic                   srch_a;
        logic                   srch_b;
        logic [BIT_IDX_W-1:0]   bit_idx;
        logic                   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_taken;
        logic zero_norm;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/csu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_if
// Valid/ready stream interfaces for element pairs and similarity results.
// ----------------------------------------------------------------------------
interface csu_in_if;
    import csu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_element;

    modport source (output valid, output elem_a, output elem_b, output last_element,
                    input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last_element,
                    output ready);
endinterface

interface csu_out_if;
    import csu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
    logic                    too_long;

    modport source (output valid, output similarity, output zero_norm, output too_long,
                    input ready);
    modport sink   (input valid, input similarity, input zero_norm, input too_long,
                    output ready);
endinterface

// ===== rtl/csu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_ctrl
// Sequencer for accumulation, wide products, root search and result load.
// ----------------------------------------------------------------------------
module csu_ctrl #(
    parameter int MAX_LEN = csu_pkg::MAX_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csu_pkg::t_dp_status i_st,
    output csu_pkg::t_dp_cmd    o_cmd
);
    import csu_pkg::*;

    localparam int NORM_W = norm_w(MAX_LEN);
    localparam int NCH    = (NORM_W + CHUNK_W - 1) / CHUNK_W;

    localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(NCH - 1);
    localparam logic [BIT_IDX_W-1:0]   TOP_BIT    = BIT_IDX_W'(R_W - 1);

    t_state                 r_state, n_state;
    logic [CHUNK_IDX_W-1:0] r_chunk, n_chunk;
    logic [BIT_IDX_W-1:0]   r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_chunk <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_chunk <= n_chunk;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_chunk = r_chunk;
        n_bit   = r_bit;
        case (r_state)
            ST_ACCUM: begin
                n_chunk = '0;
                if (i_st.last_taken) begin
                    n_state = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                if (i_st.zero_norm) begin
                    n_state = ST_EMIT;
                    n_chunk = '0;
                end else if (r_chunk == LAST_CHUNK) begin
                    n_state = ST_MUL_L;
                    n_chunk = '0;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            ST_MUL_L: begin
                n_bit = TOP_BIT;
                if (r_chunk == LAST_CHUNK) begin
                    n_state = ST_SRCH_A;
                    n_chunk = '0;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            ST_SRCH_A: begin
                n_state = ST_SRCH_B;
            end
            ST_SRCH_B: begin
                if (r_bit == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SRCH_A;
                    n_bit   = r_bit - 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_st.out_free) begin
                    n_state = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.chunk     = r_chunk;
        o_cmd.bit_idx   = r_bit;
        o_cmd.first     = (r_chunk == '0);
        case (r_state)
            ST_ACCUM:  o_cmd.take = 1'b1;
            ST_MUL_P: begin
                o_cmd.mul_p     = 1'b1;
                o_cmd.srch_init = 1'b1;
            end
            ST_MUL_L:  o_cmd.mul_l  = 1'b1;
            ST_SRCH_A: o_cmd.srch_a = 1'b1;
            ST_SRCH_B: o_cmd.srch_b = 1'b1;
            ST_EMIT:   o_cmd.emit   = i_st.out_free;
            default:   o_cmd.take   = 1'b0;
        endcase
    end

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_st.out_free) |=> (r_state == ST_ACCUM))
        else $error("result load did not return to accumulation");

endmodule

// ===== rtl/csu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_dp
// Accumulators, chunked wide multiplier, bitwise root search, output register.
// ----------------------------------------------------------------------------
module csu_dp #(
    parameter int MAX_LEN = csu_pkg::MAX_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csu_pkg::t_dp_cmd    i_cmd,
    output csu_pkg::t_dp_status o_st,
    csu_in_if.sink              i_elem,
    csu_out_if.source           o_sim
);
    import csu_pkg::*;

    localparam int NORM_W = norm_w(MAX_LEN);
    localparam int DOT_W  = NORM_W + 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = 2 * NORM_W;
    localparam int NCH    = (NORM_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCH * CHUNK_W;
    localparam int MUL_W  = NORM_W + CHUNK_W;
    localparam int T_W    = PROD_W + R_W;
    localparam int CMP_W  = PROD_W + 2 * R_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_na, r_nb;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic [PROD_W-1:0]        r_p, r_l;
    logic [CMP_W-1:0]         r_s, r_trial;
    logic [T_W-1:0]           r_t;
    logic [R_W-1:0]           r_r;
    logic                     r_o_valid;
    logic signed [SIM_W-1:0]  r_o_sim;
    logic                     r_o_zero;
    logic                     r_o_long;

    logic                     w_fire;
    logic signed [2*ELEM_W-1:0] w_pab, w_paa, w_pbb;
    logic [NORM_W-1:0]        w_mag, w_x, w_y;
    logic [PAD_W-1:0]         w_ypad;
    logic [CHUNK_W-1:0]       w_ychunk;
    logic [MUL_W-1:0]         w_prod;
    logic [PROD_W-1:0]        w_shift, w_base, w_macc;
    logic [CMP_W-1:0]         w_cand, w_lim;
    logic                     w_zero;
    logic signed [SIM_W-1:0]  w_r_ext;

    assign w_fire       = i_elem.valid && i_cmd.take;
    assign i_elem.ready = i_cmd.take;

    assign w_pab = i_elem.elem_a * i_elem.elem_b;
    assign w_paa = i_elem.elem_a * i_elem.elem_a;
    assign w_pbb = i_elem.elem_b * i_elem.elem_b;

    assign w_zero = (r_na == '0) || (r_nb == '0);
    assign w_mag  = r_dot[DOT_W-1] ? NORM_W'(-r_dot) : NORM_W'(r_dot);

    // one chunk of the y operand per cycle
    assign w_x      = i_cmd.mul_l ? w_mag : r_na;
    assign w_y      = i_cmd.mul_l ? w_mag : r_nb;
    assign w_ypad   = PAD_W'(w_y);
    assign w_ychunk = w_ypad[i_cmd.chunk * CHUNK_W +: CHUNK_W];
    assign w_prod   = MUL_W'(w_x) * MUL_W'(w_ychunk);
    assign w_shift  = PROD_W'(w_prod) << (i_cmd.chunk * CHUNK_W);
    assign w_base   = i_cmd.first ? '0 : (i_cmd.mul_l ? r_l : r_p);
    assign w_macc   = w_base + w_shift;

    // (r + 2^k)^2 * p = r^2 p + 2^(k+1) r p + 2^(2k) p
    assign w_cand  = r_trial + (CMP_W'(r_p) << {i_cmd.bit_idx, 1'b0});
    assign w_lim   = CMP_W'(r_l) << FRAC_SHIFT;
    assign w_r_ext = SIM_W'(r_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.emit) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (w_fire) begin
            if (r_cnt < CNT_MAX) begin
                r_dot <= r_dot + DOT_W'(w_pab);
                r_na  <= r_na + NORM_W'(w_paa);
                r_nb  <= r_nb + NORM_W'(w_pbb);
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_p) begin
            r_p <= w_macc;
        end
        if (i_cmd.mul_l) begin
            r_l <= w_macc;
        end
        if (i_cmd.srch_init) begin
            r_s <= '0;
            r_t <= '0;
            r_r <= '0;
        end
        if (i_cmd.srch_a) begin
            r_trial <= r_s + (CMP_W'(r_t) << (i_cmd.bit_idx + 1'b1));
        end
        if (i_cmd.srch_b && (w_cand <= w_lim)) begin
            r_s              <= w_cand;
            r_t              <= r_t + (T_W'(r_p) << i_cmd.bit_idx);
            r_r[i_cmd.bit_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_sim.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_zero <= w_zero;
            r_o_long <= r_ovf;
            if (w_zero) begin
                r_o_sim <= '0;
            end else if (r_dot[DOT_W-1]) begin
                r_o_sim <= -w_r_ext;
            end else begin
                r_o_sim <= w_r_ext;
            end
        end
    end

    assign o_sim.valid      = r_o_valid;
    assign o_sim.similarity = r_o_sim;
    assign o_sim.zero_norm  = r_o_zero;
    assign o_sim.too_long   = r_o_long;

    assign o_st.last_taken = w_fire && i_elem.last_element;
    assign o_st.zero_norm  = w_zero;
    assign o_st.out_free   = !r_o_valid || o_sim.ready;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("pair count beyond length limit");

    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_zero) |-> (r_o_sim == '0))
        else $error("zero norm result with nonzero similarity");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_sim <= SIM_ONE && r_o_sim >= -SIM_ONE))
        else $error("similarity outside unit range");

endmodule

// ===== rtl/cosine_similarity_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_unit_top
// Streaming cosine similarity of two Q.12 vectors, result in signed Q1.14.
// ----------------------------------------------------------------------------
// Element pairs are taken one per cycle while accumulating. After the pair
// marked last, the unit takes no input until its result is loaded: the
// norm product and squared dot are formed on one shared multiplier, 16 bits
// of one operand per cycle, then the 15-bit result is found by a bitwise
// search with a trial step and a compare step for each bit. A vector pair
// with a zero norm skips the remaining products and the search. The result
// sits in an output register, so the next vector streams in while it waits
// to be taken; the unit stalls only if a second result is ready before the
// first has been transferred.
module cosine_similarity_unit_top #(
    parameter int MAX_LEN = csu_pkg::MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csu_in_if.sink    i_elem,
    csu_out_if.source o_sim
);
    import csu_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_st;

    csu_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    csu_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_st    (w_st),
        .i_elem  (i_elem),
        .o_sim   (o_sim)
    );

endmodule
